### rtl/slrep_pkg.sv
// ----------------------------------------------------------------------------
// slrep_pkg
// Types, codes and the fixed SLR action/goto tables of the expression parser.
// ----------------------------------------------------------------------------
package slrep_pkg;

	localparam int NUM_STATES = 12;
	localparam int NUM_COLS   = 6;
	localparam int NUM_LHS    = 3;

	// characters
	localparam logic [7:0] CH_ID    = 8'h69;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_END   = 8'h24;
	localparam logic [7:0] CH_SKIP  = 8'h64;

	// table columns
	localparam logic [2:0] COL_ID   = 3'd0;
	localparam logic [2:0] COL_PLUS = 3'd1;
	localparam logic [2:0] COL_STAR = 3'd2;
	localparam logic [2:0] COL_LPAR = 3'd3;
	localparam logic [2:0] COL_RPAR = 3'd4;
	localparam logic [2:0] COL_END  = 3'd5;

	// action kinds
	localparam logic [3:0] ACT_NONE   = 4'h0;
	localparam logic [3:0] ACT_SHIFT  = 4'h1;
	localparam logic [3:0] ACT_REDUCE = 4'h2;
	localparam logic [3:0] ACT_ACCEPT = 4'h3;

	// status codes
	localparam logic [2:0] ST_PENDING  = 3'd0;
	localparam logic [2:0] ST_ACCEPT   = 3'd1;
	localparam logic [2:0] ST_BADSYM   = 3'd2;
	localparam logic [2:0] ST_NOACT    = 3'd3;
	localparam logic [2:0] ST_BADGOTO  = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	typedef logic [3:0] pstate_t;

	typedef struct packed {
		logic [2:0] status;
		pstate_t    fault;
	} res_t;

	typedef struct packed {
		logic       known;
		logic [2:0] col;
	} sym_dec_t;

	localparam logic [7:0] ACT_TAB [NUM_STATES][NUM_COLS] = '{
		'{8'h15, 8'h00, 8'h00, 8'h14, 8'h00, 8'h00},
		'{8'h00, 8'h16, 8'h00, 8'h00, 8'h00, 8'h30},
		'{8'h00, 8'h22, 8'h17, 8'h00, 8'h22, 8'h22},
		'{8'h00, 8'h24, 8'h24, 8'h00, 8'h24, 8'h24},
		'{8'h15, 8'h00, 8'h00, 8'h14, 8'h00, 8'h00},
		'{8'h00, 8'h26, 8'h26, 8'h00, 8'h26, 8'h26},
		'{8'h15, 8'h00, 8'h00, 8'h14, 8'h00, 8'h00},
		'{8'h15, 8'h00, 8'h00, 8'h14, 8'h00, 8'h00},
		'{8'h00, 8'h16, 8'h00, 8'h00, 8'h1B, 8'h00},
		'{8'h00, 8'h21, 8'h17, 8'h00, 8'h21, 8'h21},
		'{8'h00, 8'h23, 8'h23, 8'h00, 8'h23, 8'h23},
		'{8'h00, 8'h25, 8'h25, 8'h00, 8'h25, 8'h25}
	};

	localparam pstate_t GOTO_TAB [NUM_STATES][NUM_LHS] = '{
		'{4'd1, 4'd2, 4'd3}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd0, 4'd0}, '{4'd8, 4'd2, 4'd3}, '{4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd9, 4'd3}, '{4'd0, 4'd0, 4'd10}, '{4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}
	};

	// rule number taken mod 8 (its low three bits); slot 7 repeats slot 0
	localparam logic [1:0] RULE_LEN [8] = '{2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd1};
	localparam logic [1:0] RULE_LHS [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0};

	function automatic sym_dec_t decode_sym(input logic [7:0] sym);
		sym_dec_t d;
		d.known = 1'b1;
		case (sym)
			CH_ID:   d.col = COL_ID;
			CH_PLUS: d.col = COL_PLUS;
			CH_STAR: d.col = COL_STAR;
			CH_LPAR: d.col = COL_LPAR;
			CH_RPAR: d.col = COL_RPAR;
			CH_END:  d.col = COL_END;
			default: begin
				d.known = 1'b0;
				d.col   = COL_ID;
			end
		endcase
		return d;
	endfunction

	function automatic logic [7:0] act_lookup(input pstate_t st, input logic [2:0] col);
		logic [7:0] a;
		a = 8'h00;
		if (st < pstate_t'(NUM_STATES) && col < 3'(NUM_COLS))
			a = ACT_TAB[st][col];
		return a;
	endfunction

	function automatic pstate_t goto_lookup(input pstate_t st, input logic [1:0] lhs);
		pstate_t g;
		g = 4'd0;
		if (st < pstate_t'(NUM_STATES) && lhs < 2'(NUM_LHS))
			g = GOTO_TAB[st][lhs];
		return g;
	endfunction

endpackage

### rtl/slr_expression_parser_core.sv
// ----------------------------------------------------------------------------
// slr_expression_parser_core
// Steps: an ignored or unknown character goes from idle straight to emit; a
// table shift or verdict passes the action state first, plus a stack RAM
// read, then a goto push, per reduce; the output register follows emit.
// A new character is taken only back in idle, after the result is taken;
// the single stack RAM read port sets the pace of the reduce steps.
// Reset: asynchronous; stack empties to state 0, no RAM clearing pass.
// ----------------------------------------------------------------------------
module slr_expression_parser_core #(
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [3:0] fault_state
);

	localparam int AW = $clog2(STACK_DEPTH);

	logic               res_valid;
	logic               res_take;
	slrep_pkg::res_t    res;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	slrep_pkg::pstate_t ram_wdata;
	logic [AW-1:0]      ram_raddr;
	slrep_pkg::pstate_t ram_rdata;

	logic               out_valid_q;
	slrep_pkg::res_t    out_q;

	slrep_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.symbol    (symbol),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	slrep_ram #(
		.WIDTH(4),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take)
			out_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign fault_state = out_q.fault;

endmodule

### rtl/slrep_ram.sv
// ----------------------------------------------------------------------------
// slrep_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slrep_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### rtl/slrep_ctrl.sv
// ----------------------------------------------------------------------------
// slrep_ctrl
// Parser sequencer: decodes a character, walks the reduce chain one stack
// step at a time through the stack RAM, then shifts or gives a verdict.
// ----------------------------------------------------------------------------
module slrep_ctrl #(
	parameter int STACK_DEPTH = 64,
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        symbol,
	output logic              res_valid,
	input  logic              res_take,
	output slrep_pkg::res_t   res,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output slrep_pkg::pstate_t ram_wdata,
	output logic [AW-1:0]     ram_raddr,
	input  slrep_pkg::pstate_t ram_rdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ACT  = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	localparam logic [AW-1:0] SP_FULL = AW'(STACK_DEPTH - 1);

	logic [1:0]         state_q, state_d;
	logic [AW-1:0]      sp_q, sp_d;
	slrep_pkg::pstate_t top_q, top_d;
	logic [2:0]         col_q;
	logic               end_q;
	logic [2:0]         rule_q;
	logic               drop_q, drop_d;
	logic               wait_q, wait_d;
	slrep_pkg::res_t    res_q;

	slrep_pkg::sym_dec_t dec;
	logic [7:0]          act;
	logic [3:0]          act_kind;
	logic [3:0]          act_num;
	logic [1:0]          rlen;
	logic [AW-1:0]       rlen_w;
	slrep_pkg::pstate_t  base;
	slrep_pkg::pstate_t  nxt;
	logic                fin;
	slrep_pkg::res_t     fin_res;
	logic                fin_end;
	logic                load_in;
	logic                load_rule;

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_EMIT);
	assign res       = res_q;

	assign dec      = slrep_pkg::decode_sym(symbol);
	assign act      = slrep_pkg::act_lookup(top_q, col_q);
	assign act_kind = act[7:4];
	assign act_num  = act[3:0];
	assign rlen     = slrep_pkg::RULE_LEN[act_num[2:0]];
	assign rlen_w   = AW'(rlen);
	assign base     = (sp_q == '0) ? 4'd0 : ram_rdata;
	assign nxt      = slrep_pkg::goto_lookup(base, slrep_pkg::RULE_LHS[rule_q]);

	always_comb begin
		state_d   = state_q;
		sp_d      = sp_q;
		top_d     = top_q;
		drop_d    = drop_q;
		wait_d    = wait_q;
		fin       = 1'b0;
		fin_res   = '{status: slrep_pkg::ST_PENDING, fault: 4'd0};
		fin_end   = 1'b0;
		load_in   = 1'b0;
		load_rule = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = AW'(sp_q + 1'b1);
		ram_wdata = act_num;
		ram_raddr = AW'(sp_q - rlen_w);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (wait_q) begin
						fin = 1'b1;
						if (symbol == slrep_pkg::CH_END) begin
							sp_d   = '0;
							top_d  = 4'd0;
							drop_d = 1'b0;
							wait_d = 1'b0;
						end
					end else if (drop_q) begin
						fin    = 1'b1;
						drop_d = 1'b0;
					end else if (symbol == slrep_pkg::CH_SKIP) begin
						fin = 1'b1;
					end else if (!dec.known) begin
						fin     = 1'b1;
						fin_res = '{status: slrep_pkg::ST_BADSYM, fault: top_q};
					end else begin
						load_in = 1'b1;
						state_d = S_ACT;
					end
				end
			end
			S_ACT: begin
				fin_end = end_q;
				case (act_kind)
					slrep_pkg::ACT_ACCEPT: begin
						fin     = 1'b1;
						fin_end = 1'b1;
						fin_res = '{status: slrep_pkg::ST_ACCEPT, fault: 4'd0};
					end
					slrep_pkg::ACT_SHIFT: begin
						fin = 1'b1;
						if (sp_q == SP_FULL) begin
							fin_res = '{status: slrep_pkg::ST_OVERFLOW, fault: top_q};
						end else begin
							ram_we = 1'b1;
							sp_d   = AW'(sp_q + 1'b1);
							top_d  = act_num;
							if (col_q == slrep_pkg::COL_ID)
								drop_d = 1'b1;
						end
					end
					slrep_pkg::ACT_REDUCE: begin
						if (sp_q < rlen_w) begin
							fin     = 1'b1;
							fin_res = '{status: slrep_pkg::ST_BADGOTO, fault: top_q};
						end else begin
							sp_d      = AW'(sp_q - rlen_w);
							load_rule = 1'b1;
							state_d   = S_READ;
						end
					end
					default: begin
						fin     = 1'b1;
						fin_res = '{status: slrep_pkg::ST_NOACT, fault: top_q};
					end
				endcase
			end
			S_READ: begin
				fin_end   = end_q;
				ram_wdata = nxt;
				if (nxt == 4'd0) begin
					fin     = 1'b1;
					fin_res = '{status: slrep_pkg::ST_BADGOTO, fault: base};
				end else begin
					ram_we  = 1'b1;
					sp_d    = AW'(sp_q + 1'b1);
					top_d   = nxt;
					state_d = S_ACT;
				end
			end
			S_EMIT: begin
				if (res_take)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (fin) begin
			state_d = S_EMIT;
			if (fin_res.status != slrep_pkg::ST_PENDING) begin
				if (fin_end) begin
					sp_d   = '0;
					top_d  = 4'd0;
					drop_d = 1'b0;
					wait_d = 1'b0;
				end else begin
					wait_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
			top_q   <= 4'd0;
			drop_q  <= 1'b0;
			wait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			top_q   <= top_d;
			drop_q  <= drop_d;
			wait_q  <= wait_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			col_q <= dec.col;
			end_q <= (symbol == slrep_pkg::CH_END);
		end
		if (load_rule)
			rule_q <= act_num[2:0];
		if (fin)
			res_q <= fin_res;
	end

endmodule
